/* rtl/pst_pkg.sv */
// Shared types and constants for the priority schedule timing block.
// Used by every module of the block; depends on nothing else.

package pst_pkg;

   localparam int MAX_PROCS = 16;

   localparam int TICK_W = 16;
   localparam int PRIO_W = 8;
   localparam int SLOT_W = 4;
   localparam int TIME_W = 21;
   localparam int AVG_W  = 29;
   localparam int FRAC_W = 8;

   localparam int IDX_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);
   localparam int KEY_W      = PRIO_W + IDX_W;
   // worst case finish: every process arrives at the top tick with a full burst
   localparam int FINISH_W   = $clog2(((1 << TICK_W) - 1) * (MAX_PROCS + 1) + 1);
   localparam int TOTAL_W    = $clog2(MAX_PROCS * ((1 << TICK_W) - 1) * (MAX_PROCS + 1) + 1);
   localparam int DIVIDEND_W = TOTAL_W + FRAC_W;
   localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

   typedef struct packed {
      logic [TICK_W-1:0] arrival_time;
      logic [TICK_W-1:0] burst_time;
      logic [PRIO_W-1:0] priority_req;
      logic              last_process;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TICK_W-1:0] arrival_out;
      logic [TICK_W-1:0] burst_out;
      logic [PRIO_W-1:0] priority_out;
      logic [TIME_W-1:0] wait_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [AVG_W-1:0]  avg_wait_q8;
      logic [AVG_W-1:0]  avg_turnaround_q8;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] arrival;
      logic [TICK_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
   } proc_entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic calc;
      logic fin;
      logic accum;
      logic div_go;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic set_ready;
      logic scan_done;
      logic last_slot;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/pst_div.sv */
// Radix-2 restoring divider: two dividends over one shared small divisor.
// Depends on pst_pkg for widths.

module pst_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pst_pkg::DIVIDEND_W-1:0] dividend_a,
   input  logic [pst_pkg::DIVIDEND_W-1:0] dividend_b,
   input  logic [pst_pkg::CNT_W-1:0]      divisor,
   output logic                           done,
   output logic [pst_pkg::DIVIDEND_W-1:0] quot_a,
   output logic [pst_pkg::DIVIDEND_W-1:0] quot_b
);
   import pst_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] num_a_ff;
   logic [DIVIDEND_W-1:0] num_b_ff;
   logic [CNT_W-1:0]      rem_a_ff;
   logic [CNT_W-1:0]      rem_b_ff;
   logic [CNT_W-1:0]      div_ff;

   logic [CNT_W:0]   trial_a;
   logic [CNT_W:0]   trial_b;
   logic             ge_a;
   logic             ge_b;
   logic [CNT_W-1:0] rem_a_in;
   logic [CNT_W-1:0] rem_b_in;

   always_comb begin
      trial_a  = {rem_a_ff, num_a_ff[DIVIDEND_W-1]};
      trial_b  = {rem_b_ff, num_b_ff[DIVIDEND_W-1]};
      ge_a     = trial_a >= {1'b0, div_ff};
      ge_b     = trial_b >= {1'b0, div_ff};
      rem_a_in = ge_a ? CNT_W'(trial_a - {1'b0, div_ff}) : CNT_W'(trial_a);
      rem_b_in = ge_b ? CNT_W'(trial_b - {1'b0, div_ff}) : CNT_W'(trial_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // quotient bits shift in where the dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         num_a_ff <= dividend_a;
         num_b_ff <= dividend_b;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         num_a_ff <= {num_a_ff[DIVIDEND_W-2:0], ge_a};
         num_b_ff <= {num_b_ff[DIVIDEND_W-2:0], ge_b};
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
      end
   end

   assign done   = done_ff;
   assign quot_a = num_a_ff;
   assign quot_b = num_b_ff;

endmodule

/* rtl/pst_dp.sv */
// Datapath: process table, ordering scan, timing arithmetic, totals, result register.
// Depends on pst_pkg; instantiates pst_div.

module pst_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pst_pkg::dp_cmd_type    cmd,
   output pst_pkg::dp_status_type status,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pst_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pst_pkg::rsp_type       rsp_data
);
   import pst_pkg::*;

   proc_entry_type proc_mem_ff [MAX_PROCS];

   logic                 req_accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     slot_ff;
   logic [CNT_W-1:0]     issue_ff;
   logic                 issue_more;

   proc_entry_type       rd_data_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_vld_ff;

   logic [KEY_W-1:0]     cand_key;
   logic                 take_cand;
   logic [KEY_W-1:0]     best_key_ff;
   logic                 best_vld_ff;
   proc_entry_type       best_data_ff;
   logic [KEY_W-1:0]     last_key_ff;
   logic                 have_last_ff;

   logic [FINISH_W-1:0]  arr_ext;
   logic [FINISH_W-1:0]  burst_ext;
   logic [FINISH_W:0]    diff_in;
   logic [FINISH_W-1:0]  prev_finish_ff;
   logic [FINISH_W-1:0]  start_ff;
   logic [FINISH_W-1:0]  wt_ff;
   logic [FINISH_W-1:0]  ta_ff;
   logic [TOTAL_W-1:0]   wait_total_ff;
   logic [TOTAL_W-1:0]   ta_total_ff;

   logic                  div_done;
   logic [DIVIDEND_W-1:0] quot_wait;
   logic [DIVIDEND_W-1:0] quot_ta;

   rsp_type rsp_data_ff;
   logic    rsp_valid_ff;
   logic    last_slot;

   assign req_stall  = ~cmd.load;
   assign req_accept = req_valid & ~req_stall;
   assign issue_more = issue_ff < count_ff;
   assign last_slot  = (slot_ff + 1'b1) == count_ff;

   // load the table
   always_ff @(posedge clock) begin
      if (req_accept) begin
         proc_mem_ff[count_ff[IDX_W-1:0]] <= '{arrival: req_data.arrival_time,
                                              burst:   req_data.burst_time,
                                              prio:    req_data.priority_req};
      end
   end

   // sweep the table once per slot, one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.scan && issue_more) begin
         rd_data_ff <= proc_mem_ff[issue_ff[IDX_W-1:0]];
         rd_idx_ff  <= issue_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else if (!cmd.scan) begin
         issue_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue_more;
         if (issue_more) begin
            issue_ff <= issue_ff + 1'b1;
         end
      end
   end

   // next in run order: smallest (priority, index) above the one run last
   assign cand_key  = {rd_data_ff.prio, rd_idx_ff};
   assign take_cand = rd_vld_ff
                    & (~have_last_ff | (cand_key > last_key_ff))
                    & (~best_vld_ff | (cand_key < best_key_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_vld_ff <= 1'b0;
      end else if (cmd.calc) begin
         best_vld_ff <= 1'b0;
      end else if (take_cand) begin
         best_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_cand) begin
         best_key_ff  <= cand_key;
         best_data_ff <= rd_data_ff;
      end
   end

   // borrow of prev - arrival picks the start and the wait at once
   assign arr_ext   = FINISH_W'(best_data_ff.arrival);
   assign burst_ext = FINISH_W'(best_data_ff.burst);
   assign diff_in   = {1'b0, prev_finish_ff} - {1'b0, arr_ext};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         start_ff <= diff_in[FINISH_W] ? arr_ext : prev_finish_ff;
         wt_ff    <= diff_in[FINISH_W] ? '0 : diff_in[FINISH_W-1:0];
      end
      if (cmd.fin) begin
         ta_ff <= wt_ff + burst_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         slot_ff        <= '0;
         have_last_ff   <= 1'b0;
         last_key_ff    <= '0;
         prev_finish_ff <= '0;
         wait_total_ff  <= '0;
         ta_total_ff    <= '0;
      end else begin
         if (req_accept) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.calc) begin
            last_key_ff  <= best_key_ff;
            have_last_ff <= 1'b1;
         end
         if (cmd.fin) begin
            prev_finish_ff <= start_ff + burst_ext;
         end
         if (cmd.accum) begin
            wait_total_ff <= wait_total_ff + TOTAL_W'(wt_ff);
            ta_total_ff   <= ta_total_ff + TOTAL_W'(ta_ff);
         end
         if (cmd.emit) begin
            slot_ff <= slot_ff + 1'b1;
            // set done: clear for the next set
            if (last_slot) begin
               count_ff       <= '0;
               slot_ff        <= '0;
               have_last_ff   <= 1'b0;
               prev_finish_ff <= '0;
               wait_total_ff  <= '0;
               ta_total_ff    <= '0;
            end
         end
      end
   end

   pst_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_go),
      .dividend_a ({wait_total_ff, {FRAC_W{1'b0}}}),
      .dividend_b ({ta_total_ff, {FRAC_W{1'b0}}}),
      .divisor    (count_ff),
      .done       (div_done),
      .quot_a     (quot_wait),
      .quot_b     (quot_ta)
   );

   // result register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.slot              <= SLOT_W'(slot_ff);
         rsp_data_ff.arrival_out       <= best_data_ff.arrival;
         rsp_data_ff.burst_out         <= best_data_ff.burst;
         rsp_data_ff.priority_out      <= best_data_ff.prio;
         rsp_data_ff.wait_time         <= TIME_W'(wt_ff);
         rsp_data_ff.turnaround_time   <= TIME_W'(ta_ff);
         rsp_data_ff.avg_wait_q8       <= last_slot ? AVG_W'(quot_wait) : '0;
         rsp_data_ff.avg_turnaround_q8 <= last_slot ? AVG_W'(quot_ta) : '0;
         rsp_data_ff.last_result       <= last_slot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.set_ready = req_accept
                           & (req_data.last_process
                              | ((count_ff + 1'b1) == CNT_W'(MAX_PROCS)));
   assign status.scan_done = cmd.scan & ~issue_more & ~rd_vld_ff;
   assign status.last_slot = last_slot;
   assign status.div_done  = div_done;
   assign status.rsp_free  = ~rsp_valid_ff | ~rsp_stall;

endmodule

/* rtl/pst_ctrl.sv */
// Controller: sequences load, per-slot scan and timing steps, averaging and result hand-off.
// Depends on pst_pkg for the command and status structs.

module pst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  pst_pkg::dp_status_type status,
   output pst_pkg::dp_cmd_type    cmd
);
   import pst_pkg::*;

   typedef enum logic [7:0] {
      ST_LOAD     = 8'b0000_0001,
      ST_SCAN     = 8'b0000_0010,
      ST_CALC     = 8'b0000_0100,
      ST_FIN      = 8'b0000_1000,
      ST_ACCUM    = 8'b0001_0000,
      ST_DIV_GO   = 8'b0010_0000,
      ST_DIV_WAIT = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.set_ready) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last_slot ? ST_DIV_GO : ST_EMIT;
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for room in the result register
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_slot ? ST_LOAD : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/priority_schedule_timing.sv */
// Non-preemptive priority scheduler: top level joining controller and datapath.
// Depends on pst_pkg, pst_ctrl, pst_dp (and pst_div below it).
//
// Usage: send processes on the req_ channel, one request per process with its
// arrival, burst and priority. The set closes at a request marked last_process
// or when MAX_PROCS requests are stored. The block then emits one result per
// process on the rsp_ channel in run order: ascending priority, entry order on
// ties. Each result carries wait and turnaround times; the last result of the
// set also carries both averages in Q8 (truncated), other results carry zero.
// Timing: requests are taken back to back while loading. For a set of n processes
// each result costs one sweep of the table plus the timing arithmetic and
// hand-off; the averages add one 33-step divider pass before the last result.
// req_stall stays high from the closing request until the last result sits in
// the output register. A stalled result holds in the output register and halts
// the sequence at the next emit. Reset (synchronous) empties the table, returns
// to loading and drops any pending result.

module priority_schedule_timing (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pst_pkg::rsp_type rsp_data
);
   import pst_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   pst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/pst_check.sv */
// Port-level checks for the priority scheduler, bound to the top level.
// Depends on pst_pkg and the top level's port names.

module pst_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pst_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pst_pkg::rsp_type rsp_data
);
   import pst_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // averages appear only on the closing result
   a_avg_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |->
         rsp_data.avg_wait_q8 == '0 && rsp_data.avg_turnaround_q8 == '0)
      else $error("average on a non-final result");

   // turnaround is wait plus service
   a_ta_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.turnaround_time
                    == TIME_W'(rsp_data.wait_time + TIME_W'(rsp_data.burst_out)))
      else $error("turnaround differs from wait plus burst");

   // a closing request stops loading while the set is scheduled
   a_close_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_process |=> req_stall)
      else $error("request taken right after set closed");

endmodule

bind priority_schedule_timing pst_check u_pst_check (.*);
